>>> rtl/core/lcf_pkg.sv
// ----------------------------------------------------------------------------
// lcf_pkg
// Shared types and constants of the label collision filter.
// ----------------------------------------------------------------------------
package lcf_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] REG_MAX_PRIORITY = 2'd0;
    localparam logic [1:0] REG_LABEL_BUDGET = 2'd1;
    localparam logic [1:0] REG_VIEW_WIDTH   = 2'd2;
    localparam logic [1:0] REG_VIEW_HEIGHT  = 2'd3;

    // register reset values
    localparam logic [3:0]  MAX_PRIORITY_RST = 4'd9;
    localparam logic [8:0]  LABEL_BUDGET_RST = 9'd220;
    localparam logic [14:0] VIEW_WIDTH_RST   = 15'd800;
    localparam logic [14:0] VIEW_HEIGHT_RST  = 15'd600;

    // a zero view size falls back to these
    localparam logic [14:0] VIEW_WIDTH_DFLT  = 15'd800;
    localparam logic [14:0] VIEW_HEIGHT_DFLT = 15'd600;

    // keep-out band at the view border
    localparam logic signed [17:0] VIEW_MARGIN = 18'sd4;

    // input word modes
    localparam logic MODE_TRY   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic              mode;
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic signed [15:0] box_right;
        logic signed [15:0] box_bottom;
        logic [3:0]        box_priority;
    } cmd_word_t;

    typedef struct packed {
        logic       kept;
        logic [8:0] kept_count;
    } result_word_t;

    // one stored box
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
    } box_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } lcf_state_t;

endpackage

>>> rtl/core/label_collision_filter_top.sv
// ----------------------------------------------------------------------------
// label_collision_filter_top
// Greedy label placement: keeps candidate boxes that pass the priority,
// budget and view tests and overlap no box kept so far in this frame.
// ----------------------------------------------------------------------------
// Usage
//   cmd is taken at a clock edge where start is high and busy is low.
//   A try word tests one box, a clear word empties the kept store.
//   Each word yields one result word on result, valid for one cycle while
//   done is high; the receiver has no way to hold it off.
//   A clear word, a box rejected by the priority, budget or view test, or
//   a box offered to an empty store goes from accept straight to the
//   finish state. Otherwise the box is checked against the kept boxes
//   one per cycle, read from the box memory, ending early at the first
//   overlap. The single read port of the box memory sets this rate. busy
//   drops in the cycle done rises, so the next word may be accepted while
//   the result is shown.
//   Configuration words go through cfg_wr_en / cfg_addr / cfg_data and take
//   effect at the next edge; write them only while the block is idle.
//   Reset clears the kept count and loads the register defaults; the box
//   memory needs no clearing since only entries below the count are read.
// ----------------------------------------------------------------------------
module label_collision_filter_top
    import lcf_pkg::*;
#(
    parameter int MAX_LABELS = 256
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  cmd_word_t    cmd,
    output logic         done,
    output result_word_t result,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [14:0]  cfg_data
);

    localparam int CW = $clog2(MAX_LABELS + 1);
    localparam int AW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int BW = (CW > 9) ? CW : 9;
    localparam logic [BW-1:0] DEPTH_B = BW'(MAX_LABELS);

    // configuration registers
    logic [3:0]  max_priority_reg;
    logic [8:0]  label_budget_reg;
    logic [14:0] view_width_reg;
    logic [14:0] view_height_reg;

    // control and datapath
    lcf_state_t   state_reg, state_next;
    box_t         cand_reg, cand_next;
    logic         ok_reg, ok_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic         vld_reg, vld_next;
    logic         done_reg, done_next;
    result_word_t result_reg, result_next;
    box_t         rd_data_reg;

    // box memory
    box_t         mem [MAX_LABELS];

    logic         accept;
    logic         issue;
    logic         hit;
    logic         wr_en;
    logic         pre_ok;
    logic         in_view;
    logic [BW-1:0] budget_eff;
    logic [BW-1:0] total_ext;
    logic [BW-1:0] total_inc_ext;
    logic [14:0]  view_w;
    logic [14:0]  view_h;
    logic signed [17:0] lim_x;
    logic signed [17:0] lim_y;

    assign accept = start && (state_reg == ST_IDLE);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_priority_reg <= MAX_PRIORITY_RST;
            label_budget_reg <= LABEL_BUDGET_RST;
            view_width_reg   <= VIEW_WIDTH_RST;
            view_height_reg  <= VIEW_HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_MAX_PRIORITY: max_priority_reg <= cfg_data[3:0];
                REG_LABEL_BUDGET: label_budget_reg <= cfg_data[8:0];
                REG_VIEW_WIDTH:   view_width_reg   <= cfg_data;
                REG_VIEW_HEIGHT:  view_height_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // priority, budget and view tests on the incoming box
    always_comb
    begin
        view_w     = (view_width_reg == '0) ? VIEW_WIDTH_DFLT : view_width_reg;
        view_h     = (view_height_reg == '0) ? VIEW_HEIGHT_DFLT : view_height_reg;
        lim_x      = $signed({3'b000, view_w}) - VIEW_MARGIN;
        lim_y      = $signed({3'b000, view_h}) - VIEW_MARGIN;
        in_view    = ($signed({{2{cmd.box_right[15]}}, cmd.box_right}) > VIEW_MARGIN)
                  && ($signed({{2{cmd.box_left[15]}}, cmd.box_left}) < lim_x)
                  && ($signed({{2{cmd.box_bottom[15]}}, cmd.box_bottom}) > VIEW_MARGIN)
                  && ($signed({{2{cmd.box_top[15]}}, cmd.box_top}) < lim_y);
        budget_eff = (BW'(label_budget_reg) < DEPTH_B) ? BW'(label_budget_reg) : DEPTH_B;
        total_ext  = BW'(total_reg);
        pre_ok     = (cmd.box_priority <= max_priority_reg)
                  && (total_ext < budget_eff)
                  && in_view;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd.mode == MODE_CLEAR || !pre_ok || total_reg == '0)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit || (!issue && !vld_reg))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        issue = (state_reg == ST_SCAN) && ok_reg && (rd_idx_reg < total_reg);
        hit   = vld_reg
             && (cand_reg.left < rd_data_reg.right)
             && (cand_reg.right > rd_data_reg.left)
             && (cand_reg.top < rd_data_reg.bottom)
             && (cand_reg.bottom > rd_data_reg.top);
        wr_en = (state_reg == ST_FINISH) && ok_reg;
        busy  = (state_reg != ST_IDLE);
    end

    // datapath next values
    always_comb
    begin
        cand_next     = cand_reg;
        ok_next       = ok_reg;
        total_next    = total_reg;
        rd_idx_next   = rd_idx_reg;
        vld_next      = issue;
        done_next     = (state_reg == ST_FINISH);
        total_inc_ext = BW'(total_reg) + BW'(1);
        result_next.kept       = ok_reg;
        result_next.kept_count = ok_reg ? total_inc_ext[8:0] : total_ext[8:0];
        if (accept)
        begin
            cand_next.left   = cmd.box_left;
            cand_next.top    = cmd.box_top;
            cand_next.right  = cmd.box_right;
            cand_next.bottom = cmd.box_bottom;
            ok_next          = (cmd.mode == MODE_TRY) && pre_ok;
            rd_idx_next      = '0;
            if (cmd.mode == MODE_CLEAR)
                total_next = '0;
        end
        if (issue)
            rd_idx_next = rd_idx_reg + CW'(1);
        if (hit)
            ok_next = 1'b0;
        if (wr_en)
            total_next = total_reg + CW'(1);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ok_reg     <= 1'b0;
            total_reg  <= '0;
            rd_idx_reg <= '0;
            vld_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ok_reg     <= ok_next;
            total_reg  <= total_next;
            rd_idx_reg <= rd_idx_next;
            vld_reg    <= vld_next;
            done_reg   <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cand_reg   <= cand_next;
        result_reg <= result_next;
    end

    // box memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[total_reg[AW-1:0]] <= cand_reg;
        if (issue)
            rd_data_reg <= mem[rd_idx_reg[AW-1:0]];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
